[design/tsfn_pkg.sv]
// Shared types and constants for the tanh stretching factor Newton solver.
// Used by tsfn_div, tanh_stretch_factor_newton_top and the dv files; no dependencies.
package tsfn_pkg;

	localparam int FRAC_BITS_DEF  = 24;
	localparam int COUNT_BITS_DEF = 16;

	// Shared divider geometry
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_CNT_W = 7;

	// Configuration register widths
	localparam int TOL_W   = 25;
	localparam int LIMIT_W = 8;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NONPOS = 2'd1,
		STAT_NOSOL  = 2'd2,
		STAT_NOCONV = 2'd3
	} status_t;

	typedef enum logic {
		CFG_TOLERANCE  = 1'b0,
		CFG_ITER_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DS,
		ST_RC,
		ST_GUESS,
		ST_EVAL,
		ST_EV1,
		ST_EV2,
		ST_EV3,
		ST_EV4,
		ST_CHECK,
		ST_ST1,
		ST_ST2,
		ST_ST3,
		ST_ST4,
		ST_ST5,
		ST_DONE,
		ST_MUL_W,
		ST_MUL_R,
		ST_DIVQ_W,
		ST_TH_K,
		ST_TH_KW,
		ST_TH_MW,
		ST_TH_MR,
		ST_TH_NW,
		ST_TH_FIN,
		ST_TH_FW
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

[design/tsfn_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Dividend arrives MSB-aligned; nbits sets the number of steps. Uses tsfn_pkg.
module tsfn_div import tsfn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 fits;

	// Shift in the next dividend bit and trial-subtract
	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[design/tanh_stretch_factor_newton_top.sv]
// Flow: setup and the first residual, then one Newton step after another; rejected
// transactions stop before any Newton step. Variable divisions run on one
// shared bit-serial divider, and each tanh subtracts ln2 repeatedly for range reduction
// and then runs 13 series terms through that divider.
// Throughput: one item at a time; in_ready is high only in idle, and a finished
// result waits in the output register while the next transaction is taken.
// Reset: asynchronous active low; tolerance returns to 17, iteration limit to 50.
module tanh_stretch_factor_newton_top import tsfn_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [TOL_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] first_spacing,
	input  logic [30:0]        total_length,
	input  logic [15:0]        cell_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] stretch_factor,
	output logic [7:0]         steps_used
);

	localparam int CB = (COUNT_BITS < 16) ? COUNT_BITS : 16;
	localparam logic [15:0] CELL_MASK = 16'((64'd1 << CB) - 64'd1);
	localparam logic signed [31:0] ONE_Q = signed'(32'(64'd1 << FRAC_BITS));
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [63:0] Y_LIMIT = 64'd171798691840;
	localparam int Y_SH    = 33 - FRAC_BITS;
	localparam int DIVQ_SH = 32 - FRAC_BITS;
	localparam int TH_SH   = 31 - FRAC_BITS;

	// Magnitude of a signed word
	function automatic logic [31:0] mag(input logic signed [31:0] v);
		mag = v[31] ? 32'(-v) : v;
	endfunction

	// Clamp a 33-bit signed difference to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
		else if (v < -33'sh0_8000_0000) sat32 = 32'sh8000_0000;
		else sat32 = v[31:0];
	endfunction

	// Attach sign to a magnitude, saturating
	function automatic logic signed [31:0] apply_sign(input logic [64:0] m, input logic neg);
		logic [31:0] c;
		if (m > 65'h0_8000_0000) c = 32'h8000_0000;
		else c = m[31:0];
		if (neg) apply_sign = 32'(-c);
		else if (c[31]) apply_sign = 32'sh7FFF_FFFF;
		else apply_sign = c;
	endfunction

	// Aligned rounded dividend for a fixed-point quotient
	function automatic logic [63:0] divq_num(input logic signed [31:0] n,
			input logic signed [31:0] d);
		logic [63:0] v;
		v = ({32'b0, mag(n)} << FRAC_BITS) + {32'b0, mag(d[31:0]) >> 1};
		divq_num = v << DIVQ_SH;
	endfunction

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	status_t st_q, st_d;
	logic sign_q, sign_d;
	logic signed [31:0] x_q, x_d, c1_q, c1_d, c2_q, c2_d;
	logic signed [31:0] t1_q, t1_d, t2_q, t2_d, f_q, f_d;
	logic signed [31:0] s1_q, s1_d, s2_q, s2_d, tmp_q, tmp_d;
	logic signed [31:0] res_q, res_d, tx_q, tx_d;
	logic [5:0]  k_q, k_d;
	logic [37:0] ry_q, ry_d;
	logic [31:0] r_q, r_d;
	logic signed [34:0] sum_q, sum_d;
	logic [3:0]  n_q, n_d;
	logic [32:0] e_q, e_d;
	logic [15:0] cells_q, cells_d;
	logic [7:0]  steps_q, steps_d;
	logic [32:0] mx_q, mx_d;
	logic [31:0] my_q, my_d;
	logic [64:0] prod_q;
	logic [TOL_W-1:0]   tol_q;
	logic [LIMIT_W-1:0] limit_q;
	logic out_valid_q, out_valid_d;
	status_t out_status_q, out_status_d;
	logic signed [31:0] out_factor_q, out_factor_d;
	logic [7:0] out_steps_q, out_steps_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [63:0] y_w;
	logic [64:0] mul_rnd;
	logic signed [31:0] f_w, fp_w, ds_w, c1_w;
	logic [32:0] nterm_w;
	logic signed [34:0] nsum_w;
	logic [32:0] e_w;
	logic [33:0] den_w;
	logic [63:0] thnum_w;
	logic [15:0] cells_m;

	tsfn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Helper values for the sequencer
	assign y_w     = {32'b0, mag(tx_q)} << Y_SH;
	assign mul_rnd = prod_q + (65'd1 << (FRAC_BITS - 1));
	assign f_w     = sat32({t1_q[31], t1_q} - {res_q[31], res_q});
	assign fp_w    = sat32({tmp_q[31], tmp_q} - {res_q[31], res_q});
	assign ds_w    = (div_rsp.quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_rsp.quo[31:0];
	assign c1_w    = signed'(div_rsp.quo[31:0]) - ONE_Q;
	assign nterm_w = div_rsp.quo[32:0];
	assign nsum_w  = n_q[0] ? (sum_q - signed'({2'b0, nterm_w}))
		: (sum_q + signed'({2'b0, nterm_w}));
	assign e_w     = nsum_w[34] ? 33'd0 : (nsum_w[32:0] >> k_q);
	assign den_w   = 34'h1_0000_0000 + {1'b0, e_q};
	assign thnum_w = ((({31'b0, 33'h1_0000_0000 - e_q}) << FRAC_BITS)
		+ {31'b0, den_w[33:1]}) << TH_SH;
	assign cells_m = cell_count & CELL_MASK;

	// Shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= 65'(mx_q) * 65'(my_q);
	end

	// Sequencer: next state and datapath updates
	always_comb begin
		state_d = state_q; ret_d = ret_q; st_d = st_q; sign_d = sign_q;
		x_d = x_q; c1_d = c1_q; c2_d = c2_q; t1_d = t1_q; t2_d = t2_q; f_d = f_q;
		s1_d = s1_q; s2_d = s2_q; tmp_d = tmp_q; res_d = res_q; tx_d = tx_q;
		k_d = k_q; ry_d = ry_q; r_d = r_q; sum_d = sum_q; n_d = n_q; e_d = e_q;
		cells_d = cells_q; steps_d = steps_q; mx_d = mx_q; my_d = my_q;
		out_valid_d = out_valid_q && !out_ready;
		out_status_d = out_status_q; out_factor_d = out_factor_q; out_steps_d = out_steps_q;
		div_req = '0;
		in_ready = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					x_d = '0;
					steps_d = '0;
					cells_d = (cells_m == 16'd0) ? 16'd1 : cells_m;
					st_d = STAT_OK;
					if (first_spacing[31] || first_spacing == 32'sd0) begin
						st_d = STAT_NONPOS;
						state_d = ST_DONE;
					end else if (total_length == 31'd0) begin
						st_d = STAT_NOSOL;
						state_d = ST_DONE;
					end else begin
						div_req.start = 1'b1;
						div_req.num = {first_spacing[30:0], 33'b0};
						div_req.den = {3'b0, total_length};
						div_req.nbits = DIV_CNT_W'(31 + FRAC_BITS);
						state_d = ST_DS;
					end
				end
			end
			// Normalized spacing; then 1/I
			ST_DS: begin
				if (div_rsp.done) begin
					if (ds_w == 32'sd0) begin
						st_d = STAT_NONPOS;
						state_d = ST_DONE;
					end else begin
						c2_d = ds_w - ONE_Q;
						div_req.start = 1'b1;
						div_req.num = 64'h8000_0000_0000_0000;
						div_req.den = {18'b0, cells_q};
						div_req.nbits = DIV_CNT_W'(1 + FRAC_BITS);
						state_d = ST_RC;
					end
				end
			end
			ST_RC: begin
				if (div_rsp.done) begin
					c1_d = c1_w;
					if ((!c2_q[31] && c2_q != 32'sd0) || c2_q > c1_w) begin
						st_d = STAT_NOSOL;
						state_d = ST_DONE;
					end else if (c2_q == 32'sd0) begin
						x_d = '0;
						state_d = ST_EVAL;
					end else begin
						div_req.start = 1'b1;
						div_req.num = divq_num(c1_w, c2_q);
						div_req.den = {2'b0, mag(c2_q)};
						div_req.nbits = DIV_CNT_W'(32 + FRAC_BITS);
						sign_d = c1_w[31] ^ c2_q[31];
						ret_d = ST_GUESS;
						state_d = ST_DIVQ_W;
					end
				end
			end
			ST_GUESS: begin
				x_d = res_q;
				state_d = ST_EVAL;
			end
			// Residual: tanh(x*C1) - C2*tanh(x)
			ST_EVAL: begin
				mx_d = {1'b0, mag(x_q)}; my_d = mag(c1_q); sign_d = x_q[31] ^ c1_q[31];
				ret_d = ST_EV1; state_d = ST_MUL_W;
			end
			ST_EV1: begin
				tx_d = res_q; ret_d = ST_EV2; state_d = ST_TH_K;
			end
			ST_EV2: begin
				t1_d = res_q; tx_d = x_q; ret_d = ST_EV3; state_d = ST_TH_K;
			end
			ST_EV3: begin
				t2_d = res_q;
				mx_d = {1'b0, mag(c2_q)}; my_d = mag(res_q); sign_d = c2_q[31] ^ res_q[31];
				ret_d = ST_EV4; state_d = ST_MUL_W;
			end
			ST_EV4: begin
				f_d = f_w;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (mag(f_q) > {7'b0, tol_q} && steps_q < limit_q) begin
					mx_d = {1'b0, mag(t1_q)}; my_d = mag(t1_q); sign_d = 1'b0;
					ret_d = ST_ST1; state_d = ST_MUL_W;
				end else begin
					st_d = (mag(f_q) > {7'b0, tol_q}) ? STAT_NOCONV : STAT_OK;
					state_d = ST_DONE;
				end
			end
			// Derivative terms
			ST_ST1: begin
				s1_d = ONE_Q - res_q;
				mx_d = {1'b0, mag(t2_q)}; my_d = mag(t2_q); sign_d = 1'b0;
				ret_d = ST_ST2; state_d = ST_MUL_W;
			end
			ST_ST2: begin
				s2_d = ONE_Q - res_q;
				mx_d = {1'b0, mag(c1_q)}; my_d = mag(s1_q); sign_d = c1_q[31] ^ s1_q[31];
				ret_d = ST_ST3; state_d = ST_MUL_W;
			end
			ST_ST3: begin
				tmp_d = res_q;
				mx_d = {1'b0, mag(c2_q)}; my_d = mag(s2_q); sign_d = c2_q[31] ^ s2_q[31];
				ret_d = ST_ST4; state_d = ST_MUL_W;
			end
			ST_ST4: begin
				if (fp_w != 32'sd0) begin
					div_req.start = 1'b1;
					div_req.num = divq_num(f_q, fp_w);
					div_req.den = {2'b0, mag(fp_w)};
					div_req.nbits = DIV_CNT_W'(32 + FRAC_BITS);
					sign_d = f_q[31] ^ fp_w[31];
					ret_d = ST_ST5;
					state_d = ST_DIVQ_W;
				end else begin
					steps_d = steps_q + 8'd1;
					state_d = ST_EVAL;
				end
			end
			ST_ST5: begin
				x_d = sat32({x_q[31], x_q} - {res_q[31], res_q});
				steps_d = steps_q + 8'd1;
				state_d = ST_EVAL;
			end
			// Hand the result to the output register once it is free
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_status_d = st_q;
					out_factor_d = x_q;
					out_steps_d = steps_q;
					state_d = ST_IDLE;
				end
			end
			// Rounded product
			ST_MUL_W: begin
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				res_d = apply_sign(mul_rnd >> FRAC_BITS, sign_q);
				state_d = ret_q;
			end
			// Rounded quotient
			ST_DIVQ_W: begin
				if (div_rsp.done) begin
					res_d = apply_sign({1'b0, div_rsp.quo}, sign_q);
					state_d = ret_q;
				end
			end
			// tanh: range reduction by ln2
			ST_TH_K: begin
				sign_d = tx_q[31];
				if (y_w >= Y_LIMIT) begin
					e_d = '0;
					state_d = ST_TH_FIN;
				end else begin
					ry_d = y_w[37:0];
					k_d = '0;
					state_d = ST_TH_KW;
				end
			end
			// Subtract ln2 until the remainder drops below it
			ST_TH_KW: begin
				if (ry_q >= {6'b0, LN2_Q32}) begin
					ry_d = ry_q - {6'b0, LN2_Q32};
					k_d = k_q + 6'd1;
				end else begin
					r_d = ry_q[31:0];
					sum_d = 35'sh1_0000_0000;
					n_d = 4'd1;
					mx_d = 33'h1_0000_0000;
					my_d = ry_q[31:0];
					state_d = ST_TH_MW;
				end
			end
			// Taylor series of exp(-r), one term per pass
			ST_TH_MW: begin
				state_d = ST_TH_MR;
			end
			ST_TH_MR: begin
				div_req.start = 1'b1;
				div_req.num = {prod_q[63:32], 32'b0};
				div_req.den = {30'b0, n_q};
				div_req.nbits = DIV_CNT_W'(32);
				state_d = ST_TH_NW;
			end
			ST_TH_NW: begin
				if (div_rsp.done) begin
					sum_d = nsum_w;
					if (n_q == 4'd13) begin
						e_d = e_w;
						state_d = ST_TH_FIN;
					end else begin
						n_d = n_q + 4'd1;
						mx_d = nterm_w;
						my_d = r_q;
						state_d = ST_TH_MW;
					end
				end
			end
			// tanh = (1 - e) / (1 + e), rounded
			ST_TH_FIN: begin
				div_req.start = 1'b1;
				div_req.num = thnum_w;
				div_req.den = den_w;
				div_req.nbits = DIV_CNT_W'(33 + FRAC_BITS);
				state_d = ST_TH_FW;
			end
			ST_TH_FW: begin
				if (div_rsp.done) begin
					res_d = sign_q ? 32'(-div_rsp.quo[31:0]) : div_rsp.quo[31:0];
					state_d = ret_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		st_q <= st_d; sign_q <= sign_d;
		x_q <= x_d; c1_q <= c1_d; c2_q <= c2_d; t1_q <= t1_d; t2_q <= t2_d; f_q <= f_d;
		s1_q <= s1_d; s2_q <= s2_d; tmp_q <= tmp_d; res_q <= res_d; tx_q <= tx_d;
		k_q <= k_d; ry_q <= ry_d; r_q <= r_d; sum_q <= sum_d; n_q <= n_d; e_q <= e_d;
		cells_q <= cells_d; steps_q <= steps_d; mx_q <= mx_d; my_q <= my_d;
		out_status_q <= out_status_d; out_factor_q <= out_factor_d;
		out_steps_q <= out_steps_d;
	end

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(17);
			limit_q <= LIMIT_W'(50);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TOLERANCE:  tol_q <= cfg_data;
				CFG_ITER_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign stretch_factor = out_factor_q;
	assign steps_used = out_steps_q;

endmodule

[dv/tsfn_checker.sv]
// Checker for the tanh stretching factor Newton solver: watches the config, input and
// result channels, predicts each result in fixed point and compares field by field.
// Depends on tsfn_pkg for the status and register index codes.
module tsfn_checker import tsfn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [TOL_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] first_spacing,
	input  logic [30:0]        total_length,
	input  logic [15:0]        cell_count,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic signed [31:0] stretch_factor,
	input  logic [7:0]         steps_used,
	output int                 fail_count,
	output int                 waiting,
	output int                 checked,
	output int                 solved
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FB    = FRAC_BITS_DEF;
	localparam longint      ONE_Q = longint'(1) << FB;
	localparam bit [63:0]   ONE32 = 64'd1 << 32;
	localparam bit [63:0]   LN2   = 64'd2977044472;
	localparam longint      SMAX  = 64'sd2147483647;
	localparam longint      SMIN  = -64'sd2147483648;

	typedef struct packed {
		status_t     st;
		logic [31:0] factor;
		logic [7:0]  steps;
	} solve_t;

	logic [TOL_W-1:0]   tol_q;
	logic [LIMIT_W-1:0] limit_q;
	solve_t             solve_q[$];

	function automatic longint sat32(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function automatic bit [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_of(bit [63:0] m, bit neg);
		if (m > (64'd1 << 31)) m = 64'd1 << 31;
		if (neg) return -longint'(m);
		return sat32(longint'(m));
	endfunction

	function automatic longint qmul(longint a, longint b);
		bit [63:0] m;
		m = mag(a) * mag(b);
		m = (m + (64'd1 << (FB - 1))) >> FB;
		return signed_of(m, (a < 0) != (b < 0));
	endfunction

	function automatic longint qdiv(longint n, longint d);
		bit [63:0] dm, m;
		dm = mag(d);
		m  = ((mag(n) << FB) + dm / 2) / dm;
		return signed_of(m, (n < 0) != (d < 0));
	endfunction

	// exp(-r) in Q0.32 by truncated Taylor terms
	function automatic bit [63:0] exp_neg(bit [63:0] r);
		bit [63:0] term;
		longint    sum;
		term = ONE32;
		sum  = longint'(ONE32);
		for (int n = 1; n <= 13; n++) begin
			term = ((term * r) >> 32) / n;
			if (n % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		return sum < 0 ? 64'd0 : 64'(sum);
	endfunction

	function automatic longint qtanh(longint x);
		bit [63:0] y, e, den, t, k, r;
		y = (mag(x) << (32 - FB)) * 2;
		e = 0;
		if (y < 40 * ONE32) begin
			k = y / LN2;
			r = y - k * LN2;
			e = exp_neg(r) >> k;
		end
		den = ONE32 + e;
		t   = (((ONE32 - e) << FB) + den / 2) / den;
		return x < 0 ? -longint'(t) : longint'(t);
	endfunction

	function automatic solve_t newton_solve(longint fs, bit [63:0] len, bit [63:0] cells);
		solve_t    res;
		bit [63:0] q;
		longint    ds, c1, c2, x, t1, t2, f, s1, s2, fp;
		int        n;
		res = '{st: STAT_OK, factor: '0, steps: '0};
		n   = 0;
		if (cells == 0) cells = 1;
		if (fs <= 0) begin
			res.st = STAT_NONPOS;
		end else if (len == 0) begin
			res.st = STAT_NOSOL;
		end else begin
			q  = (64'(fs) << FB) / len;
			ds = q > 64'(SMAX) ? SMAX : longint'(q);
			c1 = longint'(64'(ONE_Q) / cells) - ONE_Q;
			c2 = ds - ONE_Q;
			if (ds == 0) res.st = STAT_NONPOS;
			else if (c2 > 0 || c2 > c1) res.st = STAT_NOSOL;
			else begin
				x  = (c2 == 0) ? 0 : qdiv(c1, c2);
				t1 = qtanh(qmul(x, c1));
				t2 = qtanh(x);
				f  = sat32(t1 - qmul(c2, t2));
				while (mag(f) > tol_q && n < limit_q) begin
					s1 = ONE_Q - qmul(t1, t1);
					s2 = ONE_Q - qmul(t2, t2);
					fp = sat32(qmul(c1, s1) - qmul(c2, s2));
					// a flat derivative leaves the iterate in place
					if (fp != 0) x = sat32(x - qdiv(f, fp));
					t1 = qtanh(qmul(x, c1));
					t2 = qtanh(x);
					f  = sat32(t1 - qmul(c2, t2));
					n++;
				end
				if (mag(f) > tol_q) res.st = STAT_NOCONV;
				res.factor = x[31:0];
				res.steps  = n[7:0];
			end
		end
		return res;
	endfunction

	// Track registers, queue predictions and compare results
	always @(posedge clk or negedge arst_n) begin
		solve_t exp_r;
		int     errs;
		if (!arst_n) begin
			tol_q      <= 17;
			limit_q    <= 50;
			fail_count <= 0;
			waiting    <= 0;
			checked    <= 0;
			solved     <= 0;
			solve_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_idx_t'(cfg_index) == CFG_TOLERANCE) tol_q <= cfg_data;
				else limit_q <= cfg_data[LIMIT_W-1:0];
			end
			if (in_valid && in_ready)
				solve_q = {solve_q, newton_solve(longint'(first_spacing),
					64'(total_length), 64'(cell_count))};
			if (out_valid && out_ready) begin
				if (solve_q.size() == 0) begin
					$error("result transaction with no prediction pending");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = solve_q.pop_front();
					errs  = 0;
					checked <= checked + 1;
					if (exp_r.st == STAT_OK) solved <= solved + 1;
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						errs++;
					end
					if (stretch_factor !== exp_r.factor) begin
						$error("stretch_factor expected %0d actual %0d",
							$signed(exp_r.factor), stretch_factor);
						errs++;
					end
					if (steps_used !== exp_r.steps) begin
						$error("steps_used expected %0d actual %0d", exp_r.steps, steps_used);
						errs++;
					end
					fail_count <= fail_count + errs;
				end
			end
			waiting <= solve_q.size();
		end
	end

endmodule

[dv/tb_tanh_stretch_factor_newton_top.sv]
// Testbench top for tanh_stretch_factor_newton_top: drives directed and random
// transactions over several register settings and gives the verdict.
// Depends on tsfn_pkg, the design and tsfn_checker.
module tb_tanh_stretch_factor_newton_top;
	import tsfn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1500000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = '0;
	logic [TOL_W-1:0]   cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [31:0] first_spacing = '0;
	logic [30:0]        total_length = '0;
	logic [15:0]        cell_count = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [1:0]         status;
	logic signed [31:0] stretch_factor;
	logic [7:0]         steps_used;
	int                 fail_count, waiting, checked, solved;
	int                 burst_left = 0;
	int                 idle_cycles = 0;
	bit                 long_hold = 0;
	int                 n_settings = 0;

	always #6 clk = ~clk;

	tanh_stretch_factor_newton_top i_dut (.*);

	tsfn_checker i_checker (.*);

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: switch among random stall patterns, with one long hold-off
	initial begin
		int mode;
		forever begin
			if (long_hold) begin
				out_ready = 0;
				repeat (30000) @(negedge clk);
				long_hold = 0;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(50, 400)) begin
				@(negedge clk);
				case (mode)
					0: out_ready = 1;
					1: out_ready = $urandom_range(0, 1);
					2: out_ready = ($urandom_range(0, 7) == 0);
					default: out_ready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic drain();
		while (waiting != 0 || out_valid) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [TOL_W-1:0] val);
		drain();
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_regs(logic [TOL_W-1:0] tol, logic [7:0] lim);
		write_reg(CFG_TOLERANCE, tol);
		write_reg(CFG_ITER_LIMIT, TOL_W'(lim));
		n_settings++;
	endtask

	task automatic send(logic [31:0] fs, logic [30:0] len, logic [15:0] cc);
		if (burst_left == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = $urandom_range(1, 6);
		end
		in_valid      = 1;
		first_spacing = fs;
		total_length  = len;
		cell_count    = cc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
		burst_left--;
	endtask

	// Well-formed request: spacing small enough that a solution exists
	task automatic send_solvable();
		logic [30:0] len;
		logic [15:0] cc;
		logic [31:0] fs;
		cc  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 200));
		len = 31'($urandom_range(1 << 16, 32'h7fffffff));
		fs  = 32'(len / (cc * $urandom_range(1, 30)));
		if (fs == 0) fs = 1;
		send(fs, len, cc);
	endtask

	task automatic send_noise();
		send($urandom, 31'($urandom), 16'($urandom));
	endtask

	task automatic random_phase(int count);
		repeat (count) begin
			if ($urandom_range(0, 3) != 0) send_solvable();
			else send_noise();
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: field extremes, rejections, degenerate guess
		send(32'h8000_0000, 31'h7fff_ffff, 16'd10);
		send(32'hffff_ffff, 31'd1, 16'd10);
		send(32'd0, 31'd100, 16'd10);
		send(32'd1, 31'h4000_0000, 16'd10);
		send(32'd5, 31'd0, 16'd10);
		send(32'h7fff_ffff, 31'd1, 16'd10);
		send(32'h7fff_ffff, 31'h7fff_ffff, 16'd1);
		send(32'h0100_0000, 31'h0100_0000, 16'd1);
		send(32'h0010_0000, 31'h0100_0000, 16'd0);
		send(32'h0000_1000, 31'h0100_0000, 16'hffff);
		send(32'd1, 31'h7fff_ffff, 16'hffff);
		send(32'h0008_0000, 31'h0100_0000, 16'd20);
		send(32'h0000_0100, 31'h7fff_ffff, 16'd4);
		send(32'h0010_0000, 31'h0100_0000, 16'd40);
		random_phase(20);

		// Pressure: hold the receiver while requests keep coming, then pause
		long_hold = 1;
		random_phase(10);
		drain();
		random_phase(5);

		set_regs(0, 2);
		random_phase(15);
		set_regs(25'h100_0000, 255);
		random_phase(15);
		set_regs(1000, 0);
		random_phase(15);
		set_regs(25'($urandom_range(0, 1 << 16)), 8);
		random_phase(25);
		set_regs(25'h1ff_ffff, 3);
		send(32'h0010_0000, 31'h0100_0000, 16'd40);
		set_regs(17, 50);
		random_phase(30);

		drain();
		repeat (2000) @(negedge clk);
		$display("Covered %0d results (%0d solved) over %0d register settings,",
			checked, solved, n_settings + 1);
		$display("with rejections, field extremes, a long output hold-off and bursty input.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[tanh_stretch_factor_newton_top.f]
design/tsfn_pkg.sv
design/tsfn_div.sv
design/tanh_stretch_factor_newton_top.sv
dv/tsfn_checker.sv
dv/tb_tanh_stretch_factor_newton_top.sv
